[design/ppe_pkg.sv]
package ppe_pkg;

  localparam int unsigned NCOLS       = 8;
  localparam int unsigned NENTRIES    = 64;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QDEPTH      = 2;

  localparam logic [1:0] REG_BLANK_LEVEL = 2'd0;
  localparam logic [1:0] REG_DIM_LEVEL   = 2'd1;
  localparam logic [1:0] REG_HIGH_SCAN   = 2'd2;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hff;
  localparam logic [IDX_W-1:0]  LAST_IDX  = 6'd63;

  // One classified register set, as handed from front to back
  typedef struct packed {
    logic [NCOLS-1:0][2:0] code;
    logic [NCOLS-1:0]      prio;
    logic                  black_en;
    logic [2:0]            black_row;
  } ppe_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ppe_qstat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blank_level;
    logic [DIM_W-1:0]  dim_level;
    logic              high_scan;
  } ppe_cfg_t;

endpackage

[design/ppe_front.sv]
module ppe_front (
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ppe_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  ppe_pkg::ppe_qstat_t                  qstat,
  output logic                                 push,
  output ppe_pkg::ppe_set_t                    push_set
);
  import ppe_pkg::*;

  logic [7:0] blue;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] prio;
  logic [3:0] black;

  assign blue  = in_tdata[7:0];
  assign red   = in_tdata[15:8];
  assign green = in_tdata[23:16];
  assign prio  = in_tdata[31:24];
  assign black = in_tdata[35:32];

  assign in_tready = !qstat.full;
  assign push      = in_tvalid && !qstat.full;

  always_comb begin
    for (int c = 0; c < NCOLS; c++) begin
      push_set.code[c] = {green[c], red[c], blue[c]};
    end
    push_set.prio      = prio;
    // codes 8 and below force nothing; 8 maps to row 0, which ignores it
    push_set.black_en  = black[3];
    push_set.black_row = black[2:0];
  end

endmodule

[design/ppe_queue.sv]
module ppe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ppe_pkg::ppe_set_t  push_set,
  input  logic               pop,
  output ppe_pkg::ppe_set_t  head_set,
  output ppe_pkg::ppe_qstat_t qstat
);
  import ppe_pkg::*;

  ppe_set_t   slot_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign qstat.full  = (count_r == 2'(QDEPTH));
  assign qstat.empty = (count_r == 2'd0);
  assign head_set    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_set;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QDEPTH)) else $error("queue count overflow");

endmodule

[design/ppe_back.sv]
module ppe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppe_pkg::ppe_cfg_t                 cfg,
  input  ppe_pkg::ppe_set_t                 head_set,
  input  ppe_pkg::ppe_qstat_t               qstat,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: entry_index[5:0], main_red, main_green, main_blue,
  //        alt_red, alt_green, alt_blue (8 bits each), zero pad [55:54]
  output logic [ppe_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import ppe_pkg::*;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [CHAN_W-1:0] main_r [3];
  logic [CHAN_W-1:0] alt_r [3];
  logic             last_r;

  logic              advance;
  logic              fire;
  logic [2:0]        row;
  logic [2:0]        col;
  logic [2:0]        colour;
  logic [CHAN_W-1:0] chan [3];
  logic [CHAN_W-1:0] dimmed [3];
  logic [CHAN_W+DIM_W-1:0] prod [3];

  assign row     = cnt_r[5:3];
  assign col     = cnt_r[2:0];
  assign advance = !valid_r || out_tready;
  assign fire    = advance && !qstat.empty;
  assign pop     = fire && (cnt_r == LAST_IDX);

  always_comb begin
    if (row == 3'd0 || head_set.prio[col]) begin
      colour = head_set.code[col];
    end else if (head_set.black_en && head_set.black_row == row) begin
      colour = 3'd0;
    end else begin
      colour = row;
    end
    // channel order: red, green, blue
    if (colour == 3'd0) begin
      chan[0] = cfg.blank_level;
      chan[1] = cfg.blank_level;
      chan[2] = cfg.blank_level;
    end else begin
      chan[0] = colour[1] ? CHAN_FULL : '0;
      chan[1] = colour[2] ? CHAN_FULL : '0;
      chan[2] = colour[0] ? CHAN_FULL : '0;
    end
    for (int n = 0; n < 3; n++) begin
      prod[n]   = {{DIM_W{1'b0}}, chan[n]} * {{CHAN_W{1'b0}}, cfg.dim_level};
      // keep the low byte of the shifted product: a factor above 256 can wrap
      dimmed[n] = prod[n][2*CHAN_W-1:CHAN_W];
    end
    cnt_nxt   = fire ? cnt_r + 1'b1 : cnt_r;
    valid_nxt = advance ? !qstat.empty : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      idx_r  <= cnt_r;
      last_r <= (cnt_r == LAST_IDX);
      for (int n = 0; n < 3; n++) begin
        main_r[n] <= chan[n];
        alt_r[n]  <= cfg.high_scan ? chan[n] : dimmed[n];
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, alt_r[2], alt_r[1], alt_r[0],
                       main_r[2], main_r[1], main_r[0], idx_r};

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[IDX_W-1:0] == LAST_IDX)))
    else $error("tlast does not match final entry");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (!out_tvalid || out_tdata[IDX_W-1:0] == $past(out_tdata[IDX_W-1:0]) + 1'b1))
    else $error("entry index skipped or repeated");

endmodule

[design/plane_palette_priority_expand_unit.sv]
// Palette expander: each request on the input stream carries one set of plane masks,
// priority mask and black code, and produces 64 palette entries in ascending index
// order, one per clock while the output is taken; out_tvalid for the first entry rises
// once the request is in the queue and the first entry is registered at the output.
// A two-deep queue holds the set being expanded and one more set waiting behind it,
// so a new request is taken while the current run streams out and
// runs follow each other with no gap. Each entry gives a main colour
// and a scanline colour (dimmed by dim_level unless high_scan_mode is set). Registers
// sit at byte addresses 0 (blank_level), 4 (dim_level) and 8 (high_scan_mode); write
// them only while no run is in progress.
module plane_palette_priority_expand_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: blue_plane[7:0], red_plane[15:8], green_plane[23:16],
  //        priority_mask[31:24], black_code[35:32], zero pad [39:36]
  input  logic [ppe_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: entry_index[5:0], main_red, main_green, main_blue,
  //        alt_red, alt_green, alt_blue (8 bits each), zero pad [55:54]
  output logic [ppe_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ppe_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ppe_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import ppe_pkg::*;

  ppe_cfg_t   cfg_r;
  ppe_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_sel;

  ppe_set_t   push_set;
  ppe_set_t   head_set;
  ppe_qstat_t qstat;
  logic       push;
  logic       pop;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_BLANK_LEVEL: cfg_nxt.blank_level = cfg_pwdata[CHAN_W-1:0];
        REG_DIM_LEVEL:   cfg_nxt.dim_level   = cfg_pwdata[DIM_W-1:0];
        REG_HIGH_SCAN:   cfg_nxt.high_scan   = cfg_pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
    case (reg_sel)
      REG_BLANK_LEVEL: cfg_prdata = {{(CFG_DATA_W-CHAN_W){1'b0}}, cfg_r.blank_level};
      REG_DIM_LEVEL:   cfg_prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, cfg_r.dim_level};
      REG_HIGH_SCAN:   cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.high_scan};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppe_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_set  (push_set)
  );

  ppe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_set (push_set),
    .pop      (pop),
    .head_set (head_set),
    .qstat    (qstat)
  );

  ppe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_set   (head_set),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[verif/palette_entry_checker.sv]
module palette_entry_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ppe_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ppe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic                             cfg_pready,
  input  logic [ppe_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output int unsigned                      fail_count,
  output int unsigned                      entries_pending
);
  import ppe_pkg::*;

  typedef struct packed {
    logic [3:0]        pad;
    logic [3:0]        black_code;
    logic [7:0]        priority_mask;
    logic [7:0]        green_plane;
    logic [7:0]        red_plane;
    logic [7:0]        blue_plane;
  } palette_set_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [CHAN_W-1:0] alt_blue;
    logic [CHAN_W-1:0] alt_green;
    logic [CHAN_W-1:0] alt_red;
    logic [CHAN_W-1:0] main_blue;
    logic [CHAN_W-1:0] main_green;
    logic [CHAN_W-1:0] main_red;
    logic [IDX_W-1:0]  entry_index;
  } palette_word_t;

  typedef struct packed {
    logic          last;
    palette_word_t word;
  } palette_entry_t;

  logic [CHAN_W-1:0] blank_reg;
  logic [DIM_W-1:0]  dim_reg;
  logic              high_scan_reg;
  palette_entry_t    expected_entries[$];
  int unsigned       fails = 0;

  initial begin
    fail_count      = 0;
    entries_pending = 0;
  end

  function automatic logic [CHAN_W-1:0] dimmed(input logic [CHAN_W-1:0] chan);
    logic [16:0] prod;
    prod = chan * dim_reg;
    return prod[15:8];
  endfunction

  function automatic palette_entry_t predict_entry(input logic [IDX_W-1:0] idx,
                                                   input logic [2:0] code);
    palette_entry_t e;
    logic [CHAN_W-1:0] r, g, b;
    if (code == 3'd0) begin
      r = blank_reg;
      g = blank_reg;
      b = blank_reg;
    end else begin
      r = code[1] ? CHAN_FULL : '0;
      g = code[2] ? CHAN_FULL : '0;
      b = code[0] ? CHAN_FULL : '0;
    end
    e.last             = (idx == LAST_IDX);
    e.word.pad         = '0;
    e.word.entry_index = idx;
    e.word.main_red    = r;
    e.word.main_green  = g;
    e.word.main_blue   = b;
    e.word.alt_red     = high_scan_reg ? r : dimmed(r);
    e.word.alt_green   = high_scan_reg ? g : dimmed(g);
    e.word.alt_blue    = high_scan_reg ? b : dimmed(b);
    return e;
  endfunction

  // Row 0 and priority columns take the plane colour; other rows the row colour, or zero on the black row
  function automatic void expand_set(input palette_set_t s);
    logic [2:0] code;
    for (int row = 0; row < 8; row++) begin
      for (int col = 0; col < 8; col++) begin
        if (row == 0 || s.priority_mask[col])
          code = {s.green_plane[col], s.red_plane[col], s.blue_plane[col]};
        else if (int'(s.black_code) == 8 + row)
          code = 3'd0;
        else
          code = 3'(row);
        expected_entries.push_back(predict_entry(IDX_W'(row * 8 + col), code));
      end
    end
  endfunction

  function automatic int field_bad(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
    if (want === got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    palette_entry_t want, got;
    int errs;
    errs = 0;
    if (!rst_n) begin
      blank_reg     = '0;
      dim_reg       = '0;
      high_scan_reg = 1'b0;
      expected_entries.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[1:0] == 2'b00) begin
        case (cfg_paddr[3:2])
          REG_BLANK_LEVEL: blank_reg     = cfg_pwdata[CHAN_W-1:0];
          REG_DIM_LEVEL:   dim_reg       = cfg_pwdata[DIM_W-1:0];
          REG_HIGH_SCAN:   high_scan_reg = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expand_set(in_tdata);
      if (out_tvalid && out_tready) begin
        got.last = out_tlast;
        got.word = out_tdata;
        if (expected_entries.size() == 0) begin
          $error("entry_index: expected none, got %0d", got.word.entry_index);
          errs++;
        end else begin
          want = expected_entries.pop_front();
          errs += field_bad("entry_index", want.word.entry_index, got.word.entry_index);
          errs += field_bad("main_red", want.word.main_red, got.word.main_red);
          errs += field_bad("main_green", want.word.main_green, got.word.main_green);
          errs += field_bad("main_blue", want.word.main_blue, got.word.main_blue);
          errs += field_bad("alt_red", want.word.alt_red, got.word.alt_red);
          errs += field_bad("alt_green", want.word.alt_green, got.word.alt_green);
          errs += field_bad("alt_blue", want.word.alt_blue, got.word.alt_blue);
          errs += field_bad("pad", want.word.pad, got.word.pad);
          errs += field_bad("last", want.last, got.last);
        end
      end
    end
    fails += errs;
    fail_count      <= fails;
    entries_pending <= expected_entries.size();
  end

endmodule

[verif/tb_plane_palette_priority_expand_unit.sv]
module tb_plane_palette_priority_expand_unit;
  import ppe_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int unsigned fail_count;
  int unsigned entries_pending;
  int          burst_left = 0;
  int unsigned cyc = 0;
  int          hold_cnt = 0;
  int unsigned stall_pct[4] = '{0, 20, 50, 80};

  plane_palette_priority_expand_unit dut (.*);

  palette_entry_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .entries_pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall density steps through four levels, holds of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (hold_cnt != 0) begin
        out_tready <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if ($urandom_range(99) < stall_pct[cyc[12:11]]) begin
        out_tready <= 1'b0;
        hold_cnt <= $urandom_range(5);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_set(input logic [7:0] blue,
      input logic [7:0] red, input logic [7:0] green, input logic [7:0] prio,
      input logic [3:0] black);
    return {4'b0, black, prio, green, red, blue};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_set();
    logic [7:0] prio;
    logic [3:0] black;
    case ($urandom_range(3))
      0:       prio = 8'h00;
      1:       prio = 8'hff;
      default: prio = 8'($urandom);
    endcase
    // favour codes that force a row to colour zero
    black = $urandom_range(1) ? 4'(8 + $urandom_range(7)) : 4'($urandom);
    return pack_set(8'($urandom), 8'($urandom), 8'($urandom), prio, black);
  endfunction

  task automatic push_palette_set(input logic [IN_TDATA_W-1:0] set_data);
    int gap;
    in_tdata  <= set_data;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic apb_write(input logic [1:0] reg_idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (entries_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Upper bits of each write are noise and must be dropped by the block
  task automatic configure(input logic [7:0] blank, input logic [8:0] dim, input logic hs);
    wait_idle();
    apb_write(REG_BLANK_LEVEL, {24'($urandom), blank});
    apb_write(REG_DIM_LEVEL, {23'($urandom), dim});
    apb_write(REG_HIGH_SCAN, {31'($urandom), hs});
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) push_palette_set(random_set());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at their reset values
    push_palette_set(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 4'd0));
    push_palette_set(pack_set(8'hff, 8'hff, 8'hff, 8'hff, 4'd15));

    configure(8'h40, 9'd192, 1'b0);
    push_palette_set(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 4'd8));
    push_palette_set(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 4'd9));
    push_palette_set(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 4'd15));
    push_palette_set(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 4'd12));
    push_palette_set(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 4'd7));
    push_palette_set(pack_set(8'hff, 8'h00, 8'h00, 8'h00, 4'd0));
    push_palette_set(pack_set(8'h00, 8'hff, 8'h00, 8'h00, 4'd0));
    push_palette_set(pack_set(8'h00, 8'h00, 8'hff, 8'h00, 4'd0));
    // priority columns ignore the black code
    push_palette_set(pack_set(8'h55, 8'h33, 8'h0f, 8'hff, 4'd11));
    push_palette_set(pack_set(8'haa, 8'hcc, 8'hf0, 8'h5a, 4'd13));
    push_palette_set(pack_set(8'hff, 8'hff, 8'hff, 8'h00, 4'd10));
    push_palette_set(pack_set(8'h80, 8'h01, 8'h7e, 8'h81, 4'd14));

    configure(8'h00, 9'd0, 1'b0);
    random_run(30);
    configure(8'hff, 9'd256, 1'b0);
    random_run(30);
    // dimming wraps past 255
    configure(8'hff, 9'd511, 1'b0);
    random_run(30);
    configure(8'hff, 9'd256, 1'b1);
    random_run(25);
    configure(8'($urandom), 9'($urandom), 1'($urandom));
    apb_write(REG_UNUSED, $urandom);
    random_run(30);

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
design/ppe_pkg.sv
design/ppe_front.sv
design/ppe_queue.sv
design/ppe_back.sv
design/plane_palette_priority_expand_unit.sv
verif/palette_entry_checker.sv
verif/tb_plane_palette_priority_expand_unit.sv
